>>> src/iirl_pkg.sv
// Shared types, widths and codes for the indexed insert/remove list.
// Used by every module of the block; depends on nothing else.
package iirl_pkg;

    // list size and word width
    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;

    // fixed field widths of the ports
    localparam int OP_W  = 2;
    localparam int POS_W = 7;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;
    localparam int ECNT_W = 7;

    // derived widths
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // gather tree: cells per first-level group
    localparam int GROUP  = 8;
    localparam int NGROUP = (CAPACITY + GROUP - 1) / GROUP;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    // command broadcast to every cell in the accepting cycle
    typedef struct packed {
        logic                  ins;
        logic                  rem;
        logic                  tap;
        logic [CMP_W-1:0]      pos;
        logic [CMP_W-1:0]      cnt;
        logic [IDX_W-1:0]      sel;
        logic [DATA_WIDTH-1:0] value;
    } t_cmd;

    typedef logic [DATA_WIDTH-1:0] t_word;

    // cut or widen an input word to the stored width
    function automatic t_word to_word(input logic [VAL_W-1:0] v);
        logic [63:0] t;
        t = 64'(v);
        return t[DATA_WIDTH-1:0];
    endfunction

    // low bits of a stored word for the result port
    function automatic logic [VAL_W-1:0] to_result(input t_word w);
        logic [63:0] t;
        t = 64'(w);
        return t[VAL_W-1:0];
    endfunction

endpackage

>>> src/iirl_cell.sv
// One slot of the list: holds a word, shifts it up or down with its neighbours.
// Depends on iirl_pkg for the command struct and widths.
module iirl_cell (
    input  logic                        i_clk,
    input  logic [iirl_pkg::IDX_W-1:0]  i_index,
    input  iirl_pkg::t_cmd              i_cmd,
    input  iirl_pkg::t_word             i_left,
    input  iirl_pkg::t_word             i_right,
    output iirl_pkg::t_word             o_data,
    output iirl_pkg::t_word             o_tap
);

    iirl_pkg::t_word               r_data;
    iirl_pkg::t_word               n_data;
    logic [iirl_pkg::CMP_W-1:0]    idx;

    assign idx = iirl_pkg::CMP_W'(i_index);

    // pick next word: new value, lower neighbour, upper neighbour or hold
    always_comb begin
        n_data = r_data;
        if (i_cmd.ins) begin
            if (idx == i_cmd.pos) begin
                n_data = i_cmd.value;
            end else if (idx > i_cmd.pos && idx <= i_cmd.cnt) begin
                n_data = i_left;
            end
        end else if (i_cmd.rem) begin
            if (idx >= i_cmd.pos && (idx + 1'b1) < i_cmd.cnt) begin
                n_data = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    // drive the stored word onto the gather tree only when selected
    assign o_tap  = (i_cmd.tap && i_index == i_cmd.sel) ? r_data : '0;

endmodule

>>> src/iirl_tree.sv
// Registered OR tree that gathers the one selected word from all cells.
// Depends on iirl_pkg for group sizes and the word type.
module iirl_tree (
    input  logic            i_clk,
    input  logic            i_load,
    input  iirl_pkg::t_word i_taps [iirl_pkg::CAPACITY],
    output iirl_pkg::t_word o_value
);

    localparam int PADDED = iirl_pkg::NGROUP * iirl_pkg::GROUP;

    iirl_pkg::t_word taps_pad [PADDED];
    iirl_pkg::t_word n_grp    [iirl_pkg::NGROUP];
    iirl_pkg::t_word r_grp    [iirl_pkg::NGROUP];

    // pad the tap row to whole groups
    always_comb begin
        for (int i = 0; i < PADDED; i++) begin
            taps_pad[i] = (i < iirl_pkg::CAPACITY) ? i_taps[i] : '0;
        end
    end

    // first level: OR within each group
    always_comb begin
        for (int g = 0; g < iirl_pkg::NGROUP; g++) begin
            n_grp[g] = '0;
            for (int k = 0; k < iirl_pkg::GROUP; k++) begin
                n_grp[g] = n_grp[g] | taps_pad[g * iirl_pkg::GROUP + k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_grp <= n_grp;
        end
    end

    // second level: OR across the group registers
    always_comb begin
        o_value = '0;
        for (int g = 0; g < iirl_pkg::NGROUP; g++) begin
            o_value = o_value | r_grp[g];
        end
    end

endmodule

>>> src/indexed_insert_remove_list_top.sv
// Top level of the indexed insert/remove list: control, row of cells, gather tree.
// Depends on iirl_pkg, iirl_cell and iirl_tree.
//
//   channel   direction  handshake                 payload
//   request   in         i_in_valid / o_in_ready   i_opcode, i_position, i_item_value
//   response  out        o_out_valid / i_out_ready o_result_value, o_status, o_entry_count
//
// One request is taken per cycle while the response is not stalled. Its
// response passes through the registered first level of the OR tree that
// gathers the selected cell and then through the output register. Every cell
// shifts at the accepting edge itself. Reset clears the count and both
// pipeline valid flags; cell words are not cleared. When the response is
// stalled the gather stage holds its entry and no new request is taken.
module indexed_insert_remove_list_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [iirl_pkg::OP_W-1:0]   i_opcode,
    input  logic [iirl_pkg::POS_W-1:0]  i_position,
    input  logic [iirl_pkg::VAL_W-1:0]  i_item_value,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [iirl_pkg::VAL_W-1:0]  o_result_value,
    output logic [iirl_pkg::ST_W-1:0]   o_status,
    output logic [iirl_pkg::ECNT_W-1:0] o_entry_count
);

    localparam int N = iirl_pkg::CAPACITY;

    logic [iirl_pkg::CNT_W-1:0]  r_count;
    logic [iirl_pkg::CNT_W-1:0]  n_count;
    logic                        r_stage_valid;
    iirl_pkg::t_status           r_stage_status;
    logic [iirl_pkg::ECNT_W-1:0] r_stage_count;
    logic                        r_out_valid;
    logic [iirl_pkg::VAL_W-1:0]  r_out_value;
    iirl_pkg::t_status           r_out_status;
    logic [iirl_pkg::ECNT_W-1:0] r_out_count;

    logic                        accept;
    logic                        move;
    iirl_pkg::t_cmd              cmd;
    iirl_pkg::t_status           status;
    logic [iirl_pkg::CMP_W-1:0]  pos_x;
    logic [iirl_pkg::CMP_W-1:0]  cnt_x;
    logic [iirl_pkg::CMP_W-1:0]  sel_x;
    logic [iirl_pkg::CMP_W-1:0]  ncnt_x;
    iirl_pkg::t_word             gathered;

    iirl_pkg::t_word             data [N];
    iirl_pkg::t_word             taps [N];

    // handshake: gather stage moves on when the output is free
    assign move       = r_stage_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_stage_valid || move;
    assign accept     = i_in_valid && o_in_ready;

    assign pos_x = iirl_pkg::CMP_W'(i_position);
    assign cnt_x = iirl_pkg::CMP_W'(r_count);

    // decode the request into a cell command, status and next count
    always_comb begin
        cmd       = '0;
        cmd.pos   = pos_x;
        cmd.cnt   = cnt_x;
        cmd.value = iirl_pkg::to_word(i_item_value);
        status    = iirl_pkg::ST_OK;
        n_count   = r_count;
        sel_x     = pos_x;
        case (iirl_pkg::t_op'(i_opcode))
            iirl_pkg::OP_INSERT: begin
                if (pos_x > cnt_x) begin
                    status = iirl_pkg::ST_RANGE;
                end else if (cnt_x == iirl_pkg::CMP_W'(N)) begin
                    status = iirl_pkg::ST_FULL;
                end else begin
                    cmd.ins = accept;
                    n_count = r_count + 1'b1;
                end
            end
            iirl_pkg::OP_REMOVE: begin
                if (r_count == '0) begin
                    status = iirl_pkg::ST_EMPTY;
                end else if (pos_x >= cnt_x) begin
                    status = iirl_pkg::ST_RANGE;
                end else begin
                    cmd.rem = accept;
                    cmd.tap = 1'b1;
                    n_count = r_count - 1'b1;
                end
            end
            iirl_pkg::OP_READ: begin
                if (r_count == '0) begin
                    status = iirl_pkg::ST_EMPTY;
                end else begin
                    cmd.tap = 1'b1;
                    if (pos_x >= cnt_x) begin
                        sel_x = cnt_x - 1'b1;
                    end
                end
            end
            default: begin
                status = iirl_pkg::ST_OK;
            end
        endcase
        cmd.sel = sel_x[iirl_pkg::IDX_W-1:0];
    end

    assign ncnt_x = iirl_pkg::CMP_W'(n_count);

    // row of cells, each wired to its neighbours
    for (genvar i = 0; i < N; i++) begin : g_cell
        iirl_pkg::t_word left_w;
        iirl_pkg::t_word right_w;
        if (i == 0) begin : g_first
            assign left_w = '0;
        end else begin : g_mid_l
            assign left_w = data[i-1];
        end
        if (i == N - 1) begin : g_last
            assign right_w = '0;
        end else begin : g_mid_r
            assign right_w = data[i+1];
        end
        iirl_cell u_cell (
            .i_clk   (i_clk),
            .i_index (iirl_pkg::IDX_W'(i)),
            .i_cmd   (cmd),
            .i_left  (left_w),
            .i_right (right_w),
            .o_data  (data[i]),
            .o_tap   (taps[i])
        );
    end

    iirl_tree u_tree (
        .i_clk   (i_clk),
        .i_load  (accept),
        .i_taps  (taps),
        .o_value (gathered)
    );

    // count and pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= '0;
            r_stage_valid <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (accept) begin
                r_count <= n_count;
            end
            if (accept) begin
                r_stage_valid <= 1'b1;
            end else if (move) begin
                r_stage_valid <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // hold status and count beside the gather stage, then the output beat
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_stage_status <= status;
            r_stage_count  <= ncnt_x[iirl_pkg::ECNT_W-1:0];
        end
        if (move) begin
            r_out_value  <= iirl_pkg::to_result(gathered);
            r_out_status <= r_stage_status;
            r_out_count  <= r_stage_count;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_status       = r_out_status;
    assign o_entry_count  = r_out_count;

endmodule
